// ===== rtl/quaternion_slerp_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion slerp block
// Concurrent checks in simulation; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_MACROS_SVH
`define QUATERNION_SLERP_MACROS_SVH
`ifndef SYNTHESIS
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("qslerp: implication failed");
`define QS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("qslerp: forbidden condition");
`else
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared widths, item types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int IQ           = 30;              // internal Q30
    localparam int QW           = 16;              // quaternion component
    localparam int BW           = QW + 1;          // negated second quaternion
    localparam int TW           = FRAC_BITS + 1;   // blend weight
    localparam int DW           = 2 * QW + 2;      // dot product sum
    localparam int CW           = IQ + 4;          // CORDIC datapath
    localparam int RW           = 2 * IQ + 2;      // square root radicand
    localparam int SQ_STEPS     = IQ + 1;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = IQ;
    localparam int PRW          = IQ + 2 + BW;     // weight times component
    localparam int BK_STAGES    = 5 + SQ_STEPS + 2 * CORDIC_STEPS + 2 + DIV_STEPS;

    localparam logic [TW-1:0]        ONE_T    = TW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0] CORDIC_K = CW'(32'h26DD3B6A);

    typedef struct packed {
        logic [3:0][QW-1:0] a;
        logic [3:0][BW-1:0] b;
        logic [TW-1:0]      t;
        logic               lin;
        logic [IQ-1:0]      d;
    } t_item;

    typedef struct packed {
        t_item       item;
        logic [IQ:0] sin_t;
    } t_side;

    typedef struct packed {
        t_item item;
        logic  za;
        logic  ca;
        logic  zb;
        logic  cb;
    } t_dside;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 32'h3243F6A8;
            5'd1:    return 32'h1DAC6705;
            5'd2:    return 32'h0FADBAFC;
            5'd3:    return 32'h07F56EA6;
            5'd4:    return 32'h03FEAB76;
            5'd5:    return 32'h01FFD55B;
            5'd6:    return 32'h00FFFAAA;
            5'd7:    return 32'h007FFF55;
            5'd8:    return 32'h003FFFEA;
            5'd9:    return 32'h001FFFFD;
            5'd10:   return 32'h000FFFFF;
            5'd11:   return 32'h0007FFFF;
            5'd12:   return 32'h0003FFFF;
            5'd13:   return 32'h0001FFFF;
            5'd14:   return 32'h0000FFFF;
            5'd15:   return 32'h00007FFF;
            5'd16:   return 32'h00003FFF;
            5'd17:   return 32'h00001FFF;
            5'd18:   return 32'h00000FFF;
            5'd19:   return 32'h000007FF;
            5'd20:   return 32'h000003FF;
            5'd21:   return 32'h000001FF;
            5'd22:   return 32'h000000FF;
            5'd23:   return 32'h0000007F;
            5'd24:   return 32'h0000003F;
            5'd25:   return 32'h0000001F;
            5'd26:   return 32'h0000000F;
            5'd27:   return 32'h00000008;
            5'd28:   return 32'h00000004;
            5'd29:   return 32'h00000002;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qslerp_front.sv =====
// ----------------------------------------------------------------------------
// qslerp_front
// Accepts items, forms the dot product, picks the short arc, classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_front
    import qslerp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_b_w,
    input  logic [14:0]        i_blend,
    input  logic               i_q_full,
    output logic               o_busy,
    output logic               o_push,
    output t_item              o_item
);

    localparam logic signed [DW-1:0] ONE2 = DW'(1) << (2 * FRAC_BITS);

    logic                 r_vld;
    logic signed [QW-1:0] r_a [4];
    logic signed [QW-1:0] r_b [4];
    logic [TW-1:0]        r_t;
    logic signed [31:0]   r_prod [4];

    logic                 w_stall;
    logic                 w_take;
    logic signed [QW-1:0] w_a [4];
    logic signed [QW-1:0] w_b [4];
    logic [TW-1:0]        w_t;
    logic signed [DW-1:0] w_dot;
    logic signed [DW-1:0] w_abs;
    logic                 w_neg;

    assign w_stall = r_vld && i_q_full;
    assign w_take  = i_start && !w_stall;
    assign o_busy  = w_stall;
    assign o_push  = r_vld && !i_q_full;

    assign w_a = '{i_a_x, i_a_y, i_a_z, i_a_w};
    assign w_b = '{i_b_x, i_b_y, i_b_z, i_b_w};
    assign w_t = (i_blend > ONE_T) ? ONE_T : i_blend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!w_stall) begin
            r_vld <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_t <= w_t;
            for (int k = 0; k < 4; k++) begin
                r_a[k]    <= w_a[k];
                r_b[k]    <= w_b[k];
                r_prod[k] <= w_a[k] * w_b[k];
            end
        end
    end

    always_comb begin
        w_dot = DW'(r_prod[0]) + DW'(r_prod[1]) + DW'(r_prod[2]) + DW'(r_prod[3]);
        w_neg = w_dot[DW-1];
        w_abs = w_neg ? -w_dot : w_dot;
        o_item.t   = r_t;
        o_item.lin = (w_abs >= ONE2);
        // dot rescaled from Q28 to Q30; only kept when below 1.0
        o_item.d   = IQ'(w_abs <<< (IQ - 2 * FRAC_BITS));
        for (int k = 0; k < 4; k++) begin
            o_item.a[k] = r_a[k];
            o_item.b[k] = w_neg ? -BW'(r_b[k]) : BW'(r_b[k]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qslerp_fifo.sv =====
// ----------------------------------------------------------------------------
// qslerp_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_fifo
    import qslerp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_data
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CNW-1:0] r_cnt;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_cnt == CNW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qslerp_isqrt.sv =====
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_isqrt
    import qslerp_pkg::*;
(
    input  logic          i_clk,
    input  logic [RW-1:0] i_rad,
    output logic [IQ:0]   o_root
);

    logic [RW-1:0] r_rem  [SQ_STEPS];
    logic [IQ:0]   r_root [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_stage
        localparam int K = SQ_STEPS - 1 - g;
        logic [RW-1:0] w_rem;
        logic [IQ:0]   w_root;
        logic [RW-1:0] w_trial;

        if (g == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        // (root + 2^K)^2 - root^2, root has no bits at or below K
        assign w_trial = (RW'(w_root) << (K + 1)) | (RW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (w_rem >= w_trial) begin
                r_rem[g]  <= w_rem - w_trial;
                r_root[g] <= w_root | ((IQ + 1)'(1) << K);
            end else begin
                r_rem[g]  <= w_rem;
                r_root[g] <= w_root;
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/qslerp_cordic.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic
// Pipelined CORDIC: vectoring gives the angle, rotation gives the sine.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_cordic
    import qslerp_pkg::*;
#(
    parameter bit VECTORING = 1'b0
)
(
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic signed [CW-1:0] o_res
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS];
    logic signed [CW-1:0] r_y [CORDIC_STEPS];
    logic signed [CW-1:0] r_z [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        localparam logic signed [CW-1:0] ANG = CW'(atan_q30(5'(g)));
        logic signed [CW-1:0] w_x;
        logic signed [CW-1:0] w_y;
        logic signed [CW-1:0] w_z;
        logic                 w_up;

        if (g == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
        end

        // vectoring turns counterclockwise when y is negative, rotation when z is not negative
        assign w_up = VECTORING ? w_y[CW-1] : !w_z[CW-1];

        always_ff @(posedge i_clk) begin
            if (w_up) begin
                r_x[g] <= w_x - (w_y >>> g);
                r_y[g] <= w_y + (w_x >>> g);
                r_z[g] <= w_z - ANG;
            end else begin
                r_x[g] <= w_x + (w_y >>> g);
                r_y[g] <= w_y - (w_x >>> g);
                r_z[g] <= w_z + ANG;
            end
        end
    end

    assign o_res = VECTORING ? r_z[CORDIC_STEPS-1] : r_y[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/qslerp_div.sv =====
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider for a fraction num/den with num below den.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_div
    import qslerp_pkg::*;
(
    input  logic          i_clk,
    input  logic [IQ:0]   i_num,
    input  logic [IQ:0]   i_den,
    output logic [IQ-1:0] o_quo
);

    logic [IQ:0]   r_rem [DIV_STEPS];
    logic [IQ:0]   r_den [DIV_STEPS];
    logic [IQ-1:0] r_quo [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        logic [IQ:0]   w_rem;
        logic [IQ:0]   w_den;
        logic [IQ-1:0] w_quo;
        logic [IQ+1:0] w_sh;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_den = r_den[g-1];
            assign w_quo = r_quo[g-1];
        end

        assign w_sh = {w_rem, 1'b0};
        assign w_ge = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            r_den[g] <= w_den;
            r_quo[g] <= {w_quo[IQ-2:0], w_ge};
            r_rem[g] <= w_ge ? (IQ + 1)'(w_sh - {1'b0, w_den}) : w_sh[IQ:0];
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/qslerp_back.sv =====
// ----------------------------------------------------------------------------
// qslerp_back
// Slerp weights (sqrt, atan2, sines, divides) and the weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_back
    import qslerp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z,
    output logic signed [15:0] o_w
);

    localparam int MW = IQ + 1 + TW;
    localparam int SW = PRW + 1;
    localparam logic signed [SW-1:0] RND   = SW'(1) <<< (IQ - 1);
    localparam logic signed [SW-1:0] SMAX  = SW'(32767);
    localparam logic signed [SW-1:0] SMIN  = -SW'(32768);
    localparam logic [IQ:0]          W_ONE = (IQ + 1)'(1) << IQ;

    logic [BK_STAGES-1:0] r_vld;

    t_item                r_b0;
    t_item                r_i1;
    logic [2*IQ-1:0]      r_dd;
    t_item                r_la [SQ_STEPS];
    t_side                r_lb [CORDIC_STEPS];
    t_side                r_s63;
    logic [IQ:0]          r_phi_a;
    logic [IQ:0]          r_phi_b;
    t_side                r_lc [CORDIC_STEPS];
    t_dside               r_s94;
    logic [IQ:0]          r_den;
    logic [IQ:0]          r_na;
    logic [IQ:0]          r_nb;
    t_dside               r_ld [DIV_STEPS];
    t_item                r_i125;
    logic [IQ:0]          r_wa;
    logic [IQ:0]          r_wb;
    logic signed [PRW-1:0] r_pa [4];
    logic signed [PRW-1:0] r_pb [4];
    logic signed [15:0]   r_out [4];

    logic [RW-1:0]        w_rad;
    logic [IQ:0]          w_sin;
    logic signed [CW-1:0] w_theta;
    logic [IQ:0]          w_th;
    logic [MW-1:0]        w_pa;
    logic [MW-1:0]        w_pb;
    logic signed [CW-1:0] w_sa;
    logic signed [CW-1:0] w_sb;
    logic signed [CW-1:0] w_den_s;
    logic                 w_za;
    logic                 w_ca;
    logic                 w_zb;
    logic                 w_cb;
    logic [IQ-1:0]        w_qa;
    logic [IQ-1:0]        w_qb;
    t_dside               w_dl;
    logic signed [SW-1:0] w_sum [4];
    logic signed [SW-1:0] w_rs  [4];
    logic signed [15:0]   w_sat [4];

    assign o_pop   = !i_empty;
    assign o_valid = r_vld[BK_STAGES-1];
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_z     = r_out[2];
    assign o_w     = r_out[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BK_STAGES-2:0], o_pop};
        end
    end

    // take item, square the dot
    always_ff @(posedge i_clk) begin
        r_b0 <= i_item;
        r_i1 <= r_b0;
        r_dd <= r_b0.d * r_b0.d;
    end

    // sin(theta) = sqrt(1 - d^2)
    assign w_rad = (RW'(1) << (2 * IQ)) - RW'(r_dd);

    qslerp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (w_rad),
        .o_root (w_sin)
    );

    always_ff @(posedge i_clk) begin
        r_la[0] <= r_i1;
        for (int i = 1; i < SQ_STEPS; i++) begin
            r_la[i] <= r_la[i-1];
        end
    end

    // theta = atan2(sin, d)
    qslerp_cordic #(.VECTORING(1'b1)) u_atan (
        .i_clk (i_clk),
        .i_x   ($signed(CW'(r_la[SQ_STEPS-1].d))),
        .i_y   ($signed(CW'(w_sin))),
        .i_z   ('0),
        .o_res (w_theta)
    );

    always_ff @(posedge i_clk) begin
        r_lb[0] <= '{item: r_la[SQ_STEPS-1], sin_t: w_sin};
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            r_lb[i] <= r_lb[i-1];
        end
    end

    // partial angles
    assign w_th = w_theta[CW-1] ? '0 : w_theta[IQ:0];
    assign w_pa = MW'(ONE_T - r_lb[CORDIC_STEPS-1].item.t) * MW'(w_th);
    assign w_pb = MW'(r_lb[CORDIC_STEPS-1].item.t) * MW'(w_th);

    always_ff @(posedge i_clk) begin
        r_s63   <= r_lb[CORDIC_STEPS-1];
        r_phi_a <= w_pa[FRAC_BITS +: IQ + 1];
        r_phi_b <= w_pb[FRAC_BITS +: IQ + 1];
    end

    qslerp_cordic #(.VECTORING(1'b0)) u_sin_a (
        .i_clk (i_clk),
        .i_x   (CORDIC_K),
        .i_y   ('0),
        .i_z   ($signed(CW'(r_phi_a))),
        .o_res (w_sa)
    );

    qslerp_cordic #(.VECTORING(1'b0)) u_sin_b (
        .i_clk (i_clk),
        .i_x   (CORDIC_K),
        .i_y   ('0),
        .i_z   ($signed(CW'(r_phi_b))),
        .o_res (w_sb)
    );

    always_ff @(posedge i_clk) begin
        r_lc[0] <= r_s63;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            r_lc[i] <= r_lc[i-1];
        end
    end

    // weight = sin(phi)/sin(theta): zero when sin(phi) <= 0, 1.0 when at or above
    assign w_den_s = $signed(CW'(r_lc[CORDIC_STEPS-1].sin_t));
    assign w_za    = w_sa[CW-1] || (w_sa == '0);
    assign w_ca    = !w_za && (w_sa >= w_den_s);
    assign w_zb    = w_sb[CW-1] || (w_sb == '0);
    assign w_cb    = !w_zb && (w_sb >= w_den_s);

    always_ff @(posedge i_clk) begin
        r_s94 <= '{item: r_lc[CORDIC_STEPS-1].item, za: w_za, ca: w_ca,
                   zb: w_zb, cb: w_cb};
        r_den <= r_lc[CORDIC_STEPS-1].sin_t;
        r_na  <= (w_za || w_ca) ? '0 : w_sa[IQ:0];
        r_nb  <= (w_zb || w_cb) ? '0 : w_sb[IQ:0];
    end

    qslerp_div u_div_a (
        .i_clk (i_clk),
        .i_num (r_na),
        .i_den (r_den),
        .o_quo (w_qa)
    );

    qslerp_div u_div_b (
        .i_clk (i_clk),
        .i_num (r_nb),
        .i_den (r_den),
        .o_quo (w_qb)
    );

    always_ff @(posedge i_clk) begin
        r_ld[0] <= r_s94;
        for (int i = 1; i < DIV_STEPS; i++) begin
            r_ld[i] <= r_ld[i-1];
        end
    end

    assign w_dl = r_ld[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        r_i125 <= w_dl.item;
        if (w_dl.item.lin) begin
            r_wa <= (IQ + 1)'(ONE_T - w_dl.item.t) << (IQ - FRAC_BITS);
            r_wb <= (IQ + 1)'(w_dl.item.t) << (IQ - FRAC_BITS);
        end else begin
            r_wa <= w_dl.za ? '0 : (w_dl.ca ? W_ONE : {1'b0, w_qa});
            r_wb <= w_dl.zb ? '0 : (w_dl.cb ? W_ONE : {1'b0, w_qb});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_pa[k] <= $signed({1'b0, r_wa}) * $signed(r_i125.a[k]);
            r_pb[k] <= $signed({1'b0, r_wb}) * $signed(r_i125.b[k]);
        end
    end

    // round half up, then saturate
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum[k] = SW'(r_pa[k]) + SW'(r_pb[k]) + RND;
            w_rs[k]  = w_sum[k] >>> IQ;
            if (w_rs[k] > SMAX) begin
                w_sat[k] = 16'sh7FFF;
            end else if (w_rs[k] < SMIN) begin
                w_sat[k] = -16'sh8000;
            end else begin
                w_sat[k] = w_rs[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_out[k] <= w_sat[k];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point Q2.14 spherical linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
// Input channel: drive the two quaternions and the blend weight with start;
// the item transfers on a rising edge with start high and busy low. A blend
// above 1.0 is treated as 1.0.
// Output channel: o_valid is high for one cycle with the four saturated
// components; the receiver must take them in that cycle.
// An item passes through the front and queue, the square root, the atan2
// CORDIC, the sine CORDICs and the dividers, and register stages for the
// angles, weights, products and rounding.
// Throughput is one item per cycle; every back stage advances each cycle,
// so busy stays low in normal use.
// Reset (synchronous, active low) empties the queue and drops every item in
// flight; no result follows an item accepted before reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_slerp_macros.svh"

module quaternion_slerp
    import qslerp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_b_w,
    input  logic [14:0]        i_blend,
    output logic               o_valid,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_w
);

    localparam int LATENCY = BK_STAGES + 2;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_fr_item;
    t_item w_q_item;

    qslerp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_a_x    (i_a_x),
        .i_a_y    (i_a_y),
        .i_a_z    (i_a_z),
        .i_a_w    (i_a_w),
        .i_b_x    (i_b_x),
        .i_b_y    (i_b_y),
        .i_b_z    (i_b_z),
        .i_b_w    (i_b_w),
        .i_blend  (i_blend),
        .i_q_full (w_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_item   (w_fr_item)
    );

    qslerp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fr_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_q_item)
    );

    qslerp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_w     (o_out_w)
    );

    // every result comes from an earlier transfer
    `QS_ASSERT_IMP(a_result_has_item, i_clk, i_rst_n, o_valid, $past(start && !busy, LATENCY))
    // every transfer yields its result
    `QS_ASSERT_IMP(a_item_has_result, i_clk, i_rst_n, start && !busy, ##LATENCY o_valid)
    // the back drains the queue every cycle, so it never fills
    `QS_ASSERT_NEVER(a_queue_never_full, i_clk, i_rst_n, w_full)

endmodule

`default_nettype wire
